FILE: hw/rtl/dstwr_pkg.sv
// ============================================================================
// dstwr_pkg
// Shared types and constants for the double-sided two-way ranging core.
// ============================================================================
package dstwr_pkg;

    // Field widths
    localparam int STAMP_BITS  = 40;
    localparam int SEQ_BITS    = 8;
    localparam int STATUS_BITS = 2;

    // Datapath widths
    localparam int PROD_BITS = 2 * STAMP_BITS;   // full product width
    localparam int SUM_BITS  = STAMP_BITS + 1;   // sum of two intervals
    localparam int DEN_BITS  = STAMP_BITS + 2;   // sum of four intervals

    // Iteration counts of the shift-add multiplier pair and the divider
    localparam int MUL_STEPS = STAMP_BITS;
    localparam int DIV_STEPS = PROD_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD_STAMP    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_SEQ_MISMATCH = 2'd2;

    // Input transaction
    typedef struct packed {
        logic                  mode;
        logic [STAMP_BITS-1:0] stamp;
        logic                  stamp_bad;
        logic [SEQ_BITS-1:0]   peer_seq;
        logic [STAMP_BITS-1:0] peer_round;
        logic [STAMP_BITS-1:0] peer_reply;
        logic [STAMP_BITS-1:0] peer_flight;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SEQ_BITS-1:0]    sent_seq;
        logic [STAMP_BITS-1:0]  sent_round;
        logic [STAMP_BITS-1:0]  sent_reply;
        logic [STAMP_BITS-1:0]  sent_flight;
        logic [STAMP_BITS-1:0]  own_flight;
        logic [STAMP_BITS-1:0]  peer_flight_kept;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul_step;
        logic cmp;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_calc;   // incoming item is a receive with matching sequence
        logic div_skip;    // negative numerator or zero denominator
    } t_dp_stat;

endpackage

FILE: hw/rtl/double_sided_twr_ranging_core.sv
// ============================================================================
// double_sided_twr_ranging_core
// One side of a double-sided two-way ranging exchange with time-of-flight.
// ============================================================================
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  result  | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
//  A transmit item or a bad-sequence receive goes from load to commit; a
//  zero/negative case skips the divider; a matched receive runs 40 steps of the
//  shift-add multiplier pair, one compare, 80 steps of the restoring divider.
//  One item is in work at a time; the next is taken while the result waits.
//  Reset is synchronous, active low, and clears all ranging state to zero.
//  A stalled output holds its result; the commit waits for a free register.
//
module double_sided_twr_ranging_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dstwr_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dstwr_pkg::t_out_item o_out_data
);

    dstwr_pkg::t_dp_cmd  w_cmd;
    dstwr_pkg::t_dp_stat w_stat;

    // Sequencer
    dstwr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath
    dstwr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

    // At most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.mul_step, w_cmd.cmp, w_cmd.div_step, w_cmd.commit}))
        else $error("more than one datapath command active");

    // The input is not ready in the cycle after a transaction is accepted
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a transaction is in work");

    // A committed result is never lost under an output stall
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.commit && o_out_valid) |-> i_out_ready)
        else $error("result committed over a pending result");

    // Status stays within its defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == dstwr_pkg::ST_OK ||
                         o_out_data.status == dstwr_pkg::ST_BAD_STAMP ||
                         o_out_data.status == dstwr_pkg::ST_SEQ_MISMATCH))
        else $error("undefined status code on output");

endmodule

FILE: hw/rtl/dstwr_ctrl.sv
// ============================================================================
// dstwr_ctrl
// Sequencer for one ranging transaction: multiply, compare, divide, commit.
// ============================================================================
module dstwr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  dstwr_pkg::t_dp_stat i_stat,
    output dstwr_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_CMP  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic [dstwr_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic                           r_out_valid, n_out_valid;

    localparam logic [dstwr_pkg::CNT_BITS-1:0] MUL_LAST =
        dstwr_pkg::CNT_BITS'(dstwr_pkg::MUL_STEPS - 1);
    localparam logic [dstwr_pkg::CNT_BITS-1:0] DIV_LAST =
        dstwr_pkg::CNT_BITS'(dstwr_pkg::DIV_STEPS - 1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_stat.need_calc ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_cnt     = '0;
                n_state   = i_stat.div_skip ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Commit only once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on commit, drop when taken
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/dstwr_dp.sv
// ============================================================================
// dstwr_dp
// Ranging state, shift-add multipliers, restoring divider and result register.
// ============================================================================
module dstwr_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dstwr_pkg::t_in_item  i_in_data,
    input  dstwr_pkg::t_dp_cmd   i_cmd,
    output dstwr_pkg::t_dp_stat  o_stat,
    output dstwr_pkg::t_out_item o_out_data
);

    localparam int SB = dstwr_pkg::STAMP_BITS;
    localparam int PB = dstwr_pkg::PROD_BITS;
    localparam int DB = dstwr_pkg::DEN_BITS;

    // Ranging state
    logic [dstwr_pkg::SEQ_BITS-1:0] r_seq;
    logic [SB-1:0]                  r_tx_stamp;
    logic [SB-1:0]                  r_rx_stamp;
    logic [SB-1:0]                  r_round;
    logic [SB-1:0]                  r_reply;
    logic [SB-1:0]                  r_flight_own;
    logic [SB-1:0]                  r_flight_peer;

    // Working registers
    dstwr_pkg::t_in_item            r_item;
    logic                           r_calc;
    logic [PB-1:0]                  r_ma_d, r_ma_c;
    logic [SB-1:0]                  r_mb_d, r_mb_c;
    logic [PB-1:0]                  r_acc_d, r_acc_c;
    logic [dstwr_pkg::SUM_BITS-1:0] r_s1, r_s2;
    logic [DB-1:0]                  r_den;
    logic                           r_zero;
    logic [PB-1:0]                  r_num;
    logic [DB-1:0]                  r_rem;
    dstwr_pkg::t_out_item           r_out;

    logic [DB-1:0]                  w_den;
    logic                           w_neg;
    logic [DB:0]                    w_rem_sh;
    logic                           w_ge;
    logic [SB-1:0]                  w_flight;
    dstwr_pkg::t_out_item           w_out;

    // Decode the incoming transaction against the current sequence number
    assign o_stat.need_calc = i_in_data.mode && (i_in_data.peer_seq == r_seq);

    // Sign of the numerator and zero check of the denominator
    assign w_neg            = (r_acc_d < r_acc_c);
    assign w_den            = DB'(r_s1) + DB'(r_s2);
    assign o_stat.div_skip  = w_neg || (w_den == '0);

    // Restoring divider step
    assign w_rem_sh = {r_rem, r_num[PB-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    assign w_flight = r_zero ? '0 : r_num[SB-1:0];

    // Build the result from the state before the update
    always_comb begin
        w_out                  = '0;
        w_out.own_flight       = r_flight_own;
        w_out.peer_flight_kept = r_flight_peer;
        if (!r_item.mode) begin
            w_out.status      = r_item.stamp_bad ? dstwr_pkg::ST_BAD_STAMP : dstwr_pkg::ST_OK;
            w_out.sent_seq    = r_seq;
            w_out.sent_round  = r_round;
            w_out.sent_reply  = r_reply;
            w_out.sent_flight = r_flight_own;
        end else if (!r_calc) begin
            w_out.status = dstwr_pkg::ST_SEQ_MISMATCH;
        end else begin
            w_out.status           = r_item.stamp_bad ? dstwr_pkg::ST_BAD_STAMP
                                                      : dstwr_pkg::ST_OK;
            w_out.own_flight       = w_flight;
            w_out.peer_flight_kept = r_item.peer_flight;
        end
    end

    // Update ranging state on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= '0;
            r_tx_stamp    <= '0;
            r_rx_stamp    <= '0;
            r_round       <= '0;
            r_reply       <= '0;
            r_flight_own  <= '0;
            r_flight_peer <= '0;
        end else if (i_cmd.commit) begin
            if (!r_item.mode) begin
                if (!r_item.stamp_bad) begin
                    r_tx_stamp <= r_item.stamp;
                    r_seq      <= r_seq + 1'b1;
                    r_reply    <= r_item.stamp - r_rx_stamp;
                end
            end else if (!r_calc) begin
                r_seq <= r_item.peer_seq + 1'b1;
            end else begin
                r_flight_own  <= w_flight;
                r_flight_peer <= r_item.peer_flight;
                if (!r_item.stamp_bad) begin
                    r_rx_stamp <= r_item.stamp;
                    r_round    <= r_item.stamp - r_tx_stamp;
                    r_seq      <= r_seq + 1'b1;
                end
            end
        end
    end

    // Capture, multiply, compare, divide, and hold the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in_data;
            r_calc  <= o_stat.need_calc;
            r_ma_d  <= PB'(r_round);
            r_mb_d  <= i_in_data.peer_round;
            r_ma_c  <= PB'(r_reply);
            r_mb_c  <= i_in_data.peer_reply;
            r_acc_d <= '0;
            r_acc_c <= '0;
            r_s1    <= {1'b0, r_round} + {1'b0, i_in_data.peer_round};
            r_s2    <= {1'b0, r_reply} + {1'b0, i_in_data.peer_reply};
            r_zero  <= 1'b1;
        end
        if (i_cmd.mul_step) begin
            r_acc_d <= r_acc_d + (r_mb_d[0] ? r_ma_d : '0);
            r_acc_c <= r_acc_c + (r_mb_c[0] ? r_ma_c : '0);
            r_ma_d  <= {r_ma_d[PB-2:0], 1'b0};
            r_ma_c  <= {r_ma_c[PB-2:0], 1'b0};
            r_mb_d  <= {1'b0, r_mb_d[SB-1:1]};
            r_mb_c  <= {1'b0, r_mb_c[SB-1:1]};
        end
        if (i_cmd.cmp) begin
            r_num  <= r_acc_d - r_acc_c;
            r_den  <= w_den;
            r_rem  <= '0;
            r_zero <= o_stat.div_skip;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? DB'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DB-1:0];
            r_num <= {r_num[PB-2:0], w_ge};
        end
        if (i_cmd.commit) begin
            r_out <= w_out;
        end
    end

    assign o_out_data = r_out;

endmodule
